FILE: design/beac_pkg.sv
package beac_pkg;

  localparam int CoordBitsDef = 16;
  localparam int OutBits      = 15;
  localparam int ImgBits      = 15;
  localparam int MinBits      = 10;

  localparam logic [ImgBits-1:0] ImageWidthRst   = ImgBits'(640);
  localparam logic [ImgBits-1:0] ImageHeightRst  = ImgBits'(480);
  localparam logic [MinBits-1:0] MinBoxWidthRst  = MinBits'(6);
  localparam logic [MinBits-1:0] MinBoxHeightRst = MinBits'(10);

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_MIN_BOX_WIDTH  = 2'd2,
    REG_MIN_BOX_HEIGHT = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    HANDLE_CENTER = 3'd0,
    HANDLE_TOP    = 3'd1,
    HANDLE_BOTTOM = 3'd2,
    HANDLE_LEFT   = 3'd3,
    HANDLE_RIGHT  = 3'd4
  } handle_e;

  typedef enum logic {
    MODE_ABS = 1'b0,
    MODE_REL = 1'b1
  } mode_e;

  typedef struct packed {
    logic [ImgBits-1:0] image_width;
    logic [ImgBits-1:0] image_height;
    logic [MinBits-1:0] min_box_width;
    logic [MinBits-1:0] min_box_height;
  } cfg_t;

  typedef struct packed {
    logic [2:0] handle;
    logic       mode;
  } edit_ctrl_t;

endpackage

FILE: design/beac_edit.sv
module beac_edit
  import beac_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic signed [COORD_BITS-1:0]                              left_i,
  input  logic signed [COORD_BITS-1:0]                              top_i,
  input  logic signed [COORD_BITS-1:0]                              right_i,
  input  logic signed [COORD_BITS-1:0]                              bottom_i,
  input  logic signed [COORD_BITS-1:0]                              shift_x_i,
  input  logic signed [COORD_BITS-1:0]                              shift_y_i,
  input  edit_ctrl_t                                                ctrl_i,
  input  cfg_t                                                      cfg_i,
  output logic signed [((COORD_BITS + 4 > 17) ? COORD_BITS + 4 : 17)-1:0] x0_o,
  output logic signed [((COORD_BITS + 4 > 17) ? COORD_BITS + 4 : 17)-1:0] y0_o,
  output logic signed [((COORD_BITS + 4 > 17) ? COORD_BITS + 4 : 17)-1:0] x1_o,
  output logic signed [((COORD_BITS + 4 > 17) ? COORD_BITS + 4 : 17)-1:0] y1_o
);

  localparam int W = (COORD_BITS + 4 > 17) ? COORD_BITS + 4 : 17;

  logic signed [W-1:0] x0, y0, x1, y1, sx, sy;
  logic signed [W-1:0] w0, h0, w0_adj, h0_adj, hw, hh;
  logic signed [W-1:0] ex0, ey0, ex1, ey1;
  logic signed [W-1:0] dx, dy, mw, mh;

  assign x0 = W'(left_i);
  assign y0 = W'(top_i);
  assign x1 = W'(right_i);
  assign y1 = W'(bottom_i);
  assign sx = W'(shift_x_i);
  assign sy = W'(shift_y_i);
  assign mw = $signed(W'(cfg_i.min_box_width));
  assign mh = $signed(W'(cfg_i.min_box_height));

  // half size rounded toward zero
  assign w0     = x1 - x0;
  assign h0     = y1 - y0;
  assign w0_adj = w0 + $signed({{(W-1){1'b0}}, w0[W-1]});
  assign h0_adj = h0 + $signed({{(W-1){1'b0}}, h0[W-1]});
  assign hw     = w0_adj >>> 1;
  assign hh     = h0_adj >>> 1;

  always_comb begin
    ex0 = x0;
    ey0 = y0;
    ex1 = x1;
    ey1 = y1;
    if (mode_e'(ctrl_i.mode) == MODE_REL) begin
      case (handle_e'(ctrl_i.handle))
        HANDLE_CENTER: begin
          ex0 = x0 + sx;
          ex1 = x1 + sx;
          ey0 = y0 + sy;
          ey1 = y1 + sy;
        end
        HANDLE_TOP:    ey0 = y0 + sy;
        HANDLE_BOTTOM: ey1 = y1 + sy;
        HANDLE_LEFT:   ex0 = x0 + sx;
        HANDLE_RIGHT:  ex1 = x1 + sx;
        default: ;
      endcase
    end else begin
      case (handle_e'(ctrl_i.handle))
        HANDLE_CENTER: begin
          ex0 = sx - hw;
          ex1 = sx + hw;
          ey0 = sy - hh;
          ey1 = sy + hh;
        end
        HANDLE_TOP:    ey0 = sy;
        HANDLE_BOTTOM: ey1 = sy;
        HANDLE_LEFT:   ex0 = sx;
        HANDLE_RIGHT:  ex1 = sx;
        default: ;
      endcase
    end
  end

  // minimum size push on the dragged edge
  assign dx = ex1 - ex0;
  assign dy = ey1 - ey0;

  always_comb begin
    x0_o = ex0;
    x1_o = ex1;
    y0_o = ey0;
    y1_o = ey1;
    if (dy < mh) begin
      if (handle_e'(ctrl_i.handle) == HANDLE_TOP) y0_o = ey1 - mh;
      else if (handle_e'(ctrl_i.handle) == HANDLE_BOTTOM) y1_o = ey0 + mh;
    end
    if (dx < mw) begin
      if (handle_e'(ctrl_i.handle) == HANDLE_LEFT) x0_o = ex1 - mw;
      else if (handle_e'(ctrl_i.handle) == HANDLE_RIGHT) x1_o = ex0 + mw;
    end
  end

endmodule

FILE: design/beac_clip.sv
module beac_clip
  import beac_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic signed [((COORD_BITS + 4 > 17) ? COORD_BITS + 4 : 17)-1:0] x0_i,
  input  logic signed [((COORD_BITS + 4 > 17) ? COORD_BITS + 4 : 17)-1:0] y0_i,
  input  logic signed [((COORD_BITS + 4 > 17) ? COORD_BITS + 4 : 17)-1:0] x1_i,
  input  logic signed [((COORD_BITS + 4 > 17) ? COORD_BITS + 4 : 17)-1:0] y1_i,
  input  cfg_t                                                      cfg_i,
  output logic [OutBits-1:0]                                        left_o,
  output logic [OutBits-1:0]                                        top_o,
  output logic [OutBits-1:0]                                        right_o,
  output logic [OutBits-1:0]                                        bottom_o,
  output logic                                                      empty_o
);

  localparam int W = (COORD_BITS + 4 > 17) ? COORD_BITS + 4 : 17;

  logic signed [W-1:0] lx, hx, ly, hy, iw, ih;
  logic signed [W-1:0] cx0, cx1, cy0, cy1;

  assign iw = $signed(W'(cfg_i.image_width));
  assign ih = $signed(W'(cfg_i.image_height));

  // normalize
  assign lx = (x0_i < x1_i) ? x0_i : x1_i;
  assign hx = (x0_i < x1_i) ? x1_i : x0_i;
  assign ly = (y0_i < y1_i) ? y0_i : y1_i;
  assign hy = (y0_i < y1_i) ? y1_i : y0_i;

  // intersect with the image
  assign cx0 = (lx < 0)  ? '0 : lx;
  assign cy0 = (ly < 0)  ? '0 : ly;
  assign cx1 = (hx > iw) ? iw : hx;
  assign cy1 = (hy > ih) ? ih : hy;

  assign empty_o  = (cx1 <= cx0) || (cy1 <= cy0);
  assign left_o   = empty_o ? '0 : cx0[OutBits-1:0];
  assign top_o    = empty_o ? '0 : cy0[OutBits-1:0];
  assign right_o  = empty_o ? '0 : cx1[OutBits-1:0];
  assign bottom_o = empty_o ? '0 : cy1[OutBits-1:0];

endmodule

FILE: design/box_edge_adjust_and_clip_unit.sv
// a start transfer gives the done strobe via the input and result registers
// throughput: one box per cycle; edit and clip run as one pass between
// the input register and the result register
// busy_o is always low and results cannot be stalled by the receiver
// reset: asynchronous active-low, clears valid flags and loads register defaults
module box_edge_adjust_and_clip_unit
  import beac_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] left_in_i,
  input  logic signed [COORD_BITS-1:0] top_in_i,
  input  logic signed [COORD_BITS-1:0] right_in_i,
  input  logic signed [COORD_BITS-1:0] bottom_in_i,
  input  logic [2:0]                   handle_i,
  input  logic                         mode_i,
  input  logic signed [COORD_BITS-1:0] shift_x_i,
  input  logic signed [COORD_BITS-1:0] shift_y_i,
  output logic                         done_o,
  output logic [OutBits-1:0]           left_out_o,
  output logic [OutBits-1:0]           top_out_o,
  output logic [OutBits-1:0]           right_out_o,
  output logic [OutBits-1:0]           bottom_out_o,
  output logic                         box_empty_o
);

  localparam int W = (COORD_BITS + 4 > 17) ? COORD_BITS + 4 : 17;

  cfg_t cfg_q;
  logic cfg_wr;
  logic in_acc;

  logic                         in_valid_q;
  logic signed [COORD_BITS-1:0] left_q, top_q, right_q, bottom_q, sx_q, sy_q;
  edit_ctrl_t                   ctrl_q;

  logic signed [W-1:0] ex0, ey0, ex1, ey1;
  logic [OutBits-1:0]  left_d, top_d, right_d, bottom_d;
  logic                empty_d;

  logic                done_q;
  logic [OutBits-1:0]  left_out_q, top_out_q, right_out_q, bottom_out_q;
  logic                empty_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width    <= ImageWidthRst;
      cfg_q.image_height   <= ImageHeightRst;
      cfg_q.min_box_width  <= MinBoxWidthRst;
      cfg_q.min_box_height <= MinBoxHeightRst;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_IMAGE_WIDTH:    cfg_q.image_width    <= pwdata[ImgBits-1:0];
        REG_IMAGE_HEIGHT:   cfg_q.image_height   <= pwdata[ImgBits-1:0];
        REG_MIN_BOX_WIDTH:  cfg_q.min_box_width  <= pwdata[MinBits-1:0];
        REG_MIN_BOX_HEIGHT: cfg_q.min_box_height <= pwdata[MinBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_IMAGE_WIDTH:    prdata = 32'(cfg_q.image_width);
      REG_IMAGE_HEIGHT:   prdata = 32'(cfg_q.image_height);
      REG_MIN_BOX_WIDTH:  prdata = 32'(cfg_q.min_box_width);
      REG_MIN_BOX_HEIGHT: prdata = 32'(cfg_q.min_box_height);
      default:            prdata = '0;
    endcase
  end

  // input register
  assign busy_o = 1'b0;
  assign in_acc = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      left_q        <= left_in_i;
      top_q         <= top_in_i;
      right_q       <= right_in_i;
      bottom_q      <= bottom_in_i;
      sx_q          <= shift_x_i;
      sy_q          <= shift_y_i;
      ctrl_q.handle <= handle_i;
      ctrl_q.mode   <= mode_i;
    end
  end

  beac_edit #(
    .COORD_BITS(COORD_BITS)
  ) u_edit (
    .left_i   (left_q),
    .top_i    (top_q),
    .right_i  (right_q),
    .bottom_i (bottom_q),
    .shift_x_i(sx_q),
    .shift_y_i(sy_q),
    .ctrl_i   (ctrl_q),
    .cfg_i    (cfg_q),
    .x0_o     (ex0),
    .y0_o     (ey0),
    .x1_o     (ex1),
    .y1_o     (ey1)
  );

  beac_clip #(
    .COORD_BITS(COORD_BITS)
  ) u_clip (
    .x0_i    (ex0),
    .y0_i    (ey0),
    .x1_i    (ex1),
    .y1_i    (ey1),
    .cfg_i   (cfg_q),
    .left_o  (left_d),
    .top_o   (top_d),
    .right_o (right_d),
    .bottom_o(bottom_d),
    .empty_o (empty_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      left_out_q   <= left_d;
      top_out_q    <= top_d;
      right_out_q  <= right_d;
      bottom_out_q <= bottom_d;
      empty_q      <= empty_d;
    end
  end

  assign done_o       = done_q;
  assign left_out_o   = left_out_q;
  assign top_out_o    = top_out_q;
  assign right_out_o  = right_out_q;
  assign bottom_out_o = bottom_out_q;
  assign box_empty_o  = empty_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("start transfer without done strobe two cycles later");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && box_empty_o |-> left_out_o == '0 && top_out_o == '0 &&
      right_out_o == '0 && bottom_out_o == '0)
    else $error("empty box with nonzero coordinates");

  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !box_empty_o |-> left_out_o < right_out_o && top_out_o < bottom_out_o)
    else $error("nonempty box not ordered");

  a_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !box_empty_o |-> right_out_o <= cfg_q.image_width &&
      bottom_out_o <= cfg_q.image_height)
    else $error("box outside image rectangle");
`endif

endmodule
